// File: design/hilbert_key_3d_unit_macros.svh
// Assertion macros for the Hilbert key unit
`ifndef HILBERT_KEY_3D_UNIT_MACROS_SVH
`define HILBERT_KEY_3D_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HK3_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hk3 assertion failed");

// next-cycle implication
`define HK3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hk3 assertion failed");

`else

`define HK3_ASSERT_NOW(label, clk, rst, ante, cons)
`define HK3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/hk3_pkg.sv
// Types, constants and helper functions for the 3D Hilbert key unit
`timescale 1ns / 1ps

package hk3_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int WORD_W         = 32;
   localparam int KEY_W          = 3 * WORD_W;
   localparam int LEVEL_W        = 6;
   localparam int KEY_WORDS_W    = 2;

   localparam logic [KEY_WORDS_W-1:0] KEY_WORDS_RESET = 2'd3;

   // axis entry: {coordinate select, reflect}
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [2:0] AX0_INIT = {AXIS_X, 1'b0};
   localparam logic [2:0] AX1_INIT = {AXIS_Y, 1'b0};
   localparam logic [2:0] AX2_INIT = {AXIS_Z, 1'b0};

   typedef struct packed {
      logic [WORD_W-1:0] coord_x;
      logic [WORD_W-1:0] coord_y;
      logic [WORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] key_word0;
      logic [WORD_W-1:0] key_word1;
      logic [WORD_W-1:0] key_word2;
   } rsp_type;

   // state carried down the pipeline
   typedef struct packed {
      logic [WORD_W-1:0]  crd_x;
      logic [WORD_W-1:0]  crd_y;
      logic [WORD_W-1:0]  crd_z;
      logic [2:0]         ax0;
      logic [2:0]         ax1;
      logic [2:0]         ax2;
      logic [LEVEL_W-1:0] levels;
      logic [KEY_W-1:0]   key;
   } hk3_pipe_type;

   function automatic logic [2:0] gray_to_digit(logic [2:0] g);
      logic [2:0] d;
      case (g)
         3'd0:    d = 3'd0;
         3'd1:    d = 3'd1;
         3'd2:    d = 3'd3;
         3'd3:    d = 3'd2;
         3'd4:    d = 3'd7;
         3'd5:    d = 3'd6;
         3'd6:    d = 3'd4;
         default: d = 3'd5;
      endcase
      return d;
   endfunction

   function automatic logic crd_bit(hk3_pipe_type p, logic [1:0] sel, logic [4:0] pos);
      logic b;
      case (sel)
         AXIS_X:  b = p.crd_x[pos];
         AXIS_Y:  b = p.crd_y[pos];
         default: b = p.crd_z[pos];
      endcase
      return b;
   endfunction

endpackage

// File: design/hk3_stage.sv
// One pipeline stage of the Hilbert key unit: a few levels plus a register
`timescale 1ns / 1ps

module hk3_stage #(
   parameter int COORD_BITS  = hk3_pkg::COORD_BITS_DEF,
   parameter int FIRST_LEVEL = 0,
   parameter int NUM_LEVELS  = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hk3_pkg::hk3_pipe_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hk3_pkg::hk3_pipe_type out_data
);
   import hk3_pkg::*;

   localparam int KEY_BITS = 3 * COORD_BITS;

   logic         valid_ff, valid_in;
   hk3_pipe_type data_ff, data_in;

   always_comb begin
      logic [2:0] p0, p1, p2, g, d;
      int         lv, s, kb;
      p0 = '0;
      p1 = '0;
      p2 = '0;
      g  = '0;
      d  = '0;
      data_in = in_data;
      for (int j = 0; j < NUM_LEVELS; j++) begin
         lv = FIRST_LEVEL + j;
         s  = COORD_BITS - 1 - lv;
         kb = KEY_BITS - 1 - 3 * lv;
         if (LEVEL_W'(lv) < data_in.levels) begin
            p0 = data_in.ax0;
            p1 = data_in.ax1;
            p2 = data_in.ax2;
            g  = {crd_bit(data_in, p2[2:1], 5'(s)) ^ p2[0],
                  crd_bit(data_in, p1[2:1], 5'(s)) ^ p1[0],
                  crd_bit(data_in, p0[2:1], 5'(s)) ^ p0[0]};
            d  = gray_to_digit(g);
            data_in.key[kb -: 3] = d;
            // axis order and reflections for the next level
            case (d)
               3'd0: begin
                  data_in.ax0 = p2;
                  data_in.ax1 = p1;
                  data_in.ax2 = p0;
               end
               3'd1: begin
                  data_in.ax0 = p0;
                  data_in.ax1 = p2;
                  data_in.ax2 = p1;
               end
               3'd3: begin
                  data_in.ax0 = p2 ^ 3'd1;
                  data_in.ax1 = p0 ^ 3'd1;
                  data_in.ax2 = p1;
               end
               3'd4: begin
                  data_in.ax0 = p2;
                  data_in.ax1 = p0 ^ 3'd1;
                  data_in.ax2 = p1 ^ 3'd1;
               end
               3'd6: begin
                  data_in.ax0 = p0;
                  data_in.ax1 = p2 ^ 3'd1;
                  data_in.ax2 = p1 ^ 3'd1;
               end
               3'd7: begin
                  data_in.ax0 = p2 ^ 3'd1;
                  data_in.ax1 = p1;
                  data_in.ax2 = p0 ^ 3'd1;
               end
               default: begin
                  // digits 2 and 5 keep the order
               end
            endcase
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/hilbert_key_3d_unit.sv
// Top level of the 3D Hilbert key unit
`timescale 1ns / 1ps
`include "hilbert_key_3d_unit_macros.svh"

// Computes the 3D Hilbert curve key of a point (coord_x, coord_y, coord_z).
// Request channel req_*: valid/ready, payload req_data (three coordinates).
// Result channel rsp_*: valid/ready, payload rsp_data (three key words,
// most significant first; unused low bits and words read as zero).
// Config channel csr_*: csr_data sets key_words (0..3), the number of key
// words filled; levels encoded = floor(COORD_BITS * key_words / 3).
// csr_ready is always high; write it only while no request is in flight.
// Throughput: one request per cycle while rsp_ready is high. Each request passes
// through the NUM_STAGES stage registers in order before rsp_valid rises.
// NUM_STAGES = ceil(COORD_BITS / LPS) with LPS = ceil(COORD_BITS / 8) levels per
// stage; 8 stages at COORD_BITS = 32.
// The level walk is a chain of axis updates, cut into those stages.
// Reset empties the pipeline and sets key_words to 3.
// When rsp_ready is low, each stage holds its request; free stages still
// fill, so req_ready drops only once every stage is occupied.
module hilbert_key_3d_unit #(
   parameter int COORD_BITS = hk3_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hk3_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hk3_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hk3_pkg::KEY_WORDS_W-1:0]      csr_data
);
   import hk3_pkg::*;

   localparam int LPS        = (COORD_BITS + 7) / 8;
   localparam int NUM_STAGES = (COORD_BITS + LPS - 1) / LPS;
   localparam int KEY_BITS   = 3 * COORD_BITS;

   localparam logic [LEVEL_W-1:0] LEVELS_1 = LEVEL_W'(COORD_BITS / 3);
   localparam logic [LEVEL_W-1:0] LEVELS_2 = LEVEL_W'((2 * COORD_BITS) / 3);
   localparam logic [LEVEL_W-1:0] LEVELS_3 = LEVEL_W'(COORD_BITS);

   logic [KEY_WORDS_W-1:0] key_words_ff;
   logic [LEVEL_W-1:0]     req_levels;

   logic         stg_valid [NUM_STAGES+1];
   logic         stg_ready [NUM_STAGES+1];
   hk3_pipe_type stg_data  [NUM_STAGES+1];

   hk3_pipe_type entry_data;
   hk3_pipe_type last;
   logic [KEY_BITS-1:0] out_key;
   logic [KEY_BITS-1:0] key_tail;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_words_ff <= KEY_WORDS_RESET;
      end else if (csr_valid && csr_ready) begin
         key_words_ff <= csr_data;
      end
   end

   always_comb begin
      case (key_words_ff)
         2'd0:    req_levels = '0;
         2'd1:    req_levels = LEVELS_1;
         2'd2:    req_levels = LEVELS_2;
         default: req_levels = LEVELS_3;
      endcase
   end

   // pipeline entry
   assign stg_valid[0] = req_valid;
   assign req_ready    = stg_ready[0];

   always_comb begin
      entry_data        = '0;
      entry_data.crd_x  = req_data.coord_x;
      entry_data.crd_y  = req_data.coord_y;
      entry_data.crd_z  = req_data.coord_z;
      entry_data.ax0    = AX0_INIT;
      entry_data.ax1    = AX1_INIT;
      entry_data.ax2    = AX2_INIT;
      entry_data.levels = req_levels;
   end

   assign stg_data[0] = entry_data;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      localparam int FIRST = k * LPS;
      localparam int NUM   = (COORD_BITS - FIRST < LPS) ? COORD_BITS - FIRST : LPS;

      hk3_stage #(
         .COORD_BITS  (COORD_BITS),
         .FIRST_LEVEL (FIRST),
         .NUM_LEVELS  (NUM)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   // pipeline exit
   assign last                  = stg_data[NUM_STAGES];
   assign rsp_valid             = stg_valid[NUM_STAGES];
   assign stg_ready[NUM_STAGES] = rsp_ready;

   assign out_key  = last.key[KEY_BITS-1:0];
   // bits below the last written digit
   assign key_tail = out_key << (3 * last.levels);

   assign rsp_data.key_word0 = WORD_W'(out_key[KEY_BITS-1 -: COORD_BITS]);
   assign rsp_data.key_word1 = WORD_W'(out_key[KEY_BITS-1-COORD_BITS -: COORD_BITS]);
   assign rsp_data.key_word2 = WORD_W'(out_key[COORD_BITS-1:0]);

   `HK3_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, stg_valid[1])
   `HK3_ASSERT_NOW(a_levels_bound, clock, reset, rsp_valid, last.levels <= LEVELS_3)
   `HK3_ASSERT_NOW(a_no_levels_zero_key, clock, reset, rsp_valid && last.levels == '0, out_key == '0)
   `HK3_ASSERT_NOW(a_tail_clear, clock, reset, rsp_valid, key_tail == '0)

endmodule

// File: bench/tb_hilbert_key_3d_unit.sv
// Self-checking testbench for the 3D Hilbert key unit
`timescale 1ns / 1ps

module tb_hilbert_key_3d_unit;
   import hk3_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 80;
   localparam int STALL_AT    = 150;
   localparam int SETTLE      = 16;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int PAUSE_PHASE = 3;

   // initial axis entries: {coordinate select, reflect}
   localparam logic [2:0] START_AX0 = 3'b000;
   localparam logic [2:0] START_AX1 = 3'b010;
   localparam logic [2:0] START_AX2 = 3'b100;

   typedef struct {
      logic [KEY_WORDS_W-1:0] key_words;
      req_type                pt;
      bit                     typed;
      rsp_type                key;
   } point_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [KEY_WORDS_W-1:0] csr_data;

   rsp_type pending_keys[$];
   point_row_type point_rows[$];
   logic [KEY_WORDS_W-1:0] key_words_now;
   int errors = 0;
   int points_sent = 0;
   int keys_checked = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit stall_pending = 1'b1;

   hilbert_key_3d_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic axis_bit(req_type pt, logic [2:0] ax, int s);
      logic b;
      case (ax[2:1])
         2'd0:    b = pt.coord_x[s];
         2'd1:    b = pt.coord_y[s];
         2'd2:    b = pt.coord_z[s];
         default: b = 1'b0;
      endcase
      return b ^ ax[0];
   endfunction

   // Hilbert key of one point at the given key-word count
   function automatic rsp_type hilbert_key(req_type pt, logic [KEY_WORDS_W-1:0] kw);
      logic [KEY_W-1:0] key;
      logic [2:0] ax0, ax1, ax2, p0, p1, p2, g, d;
      int levels, lv, s;
      key = '0;
      ax0 = START_AX0;
      ax1 = START_AX1;
      ax2 = START_AX2;
      levels = (WORD_W * int'(kw)) / 3;
      for (lv = 0; lv < levels; lv++) begin
         s = WORD_W - 1 - lv;
         g = {axis_bit(pt, ax2, s), axis_bit(pt, ax1, s), axis_bit(pt, ax0, s)};
         // Gray decode
         d = {g[2], g[2] ^ g[1], g[2] ^ g[1] ^ g[0]};
         key[KEY_W - 1 - 3 * lv -: 3] = d;
         p0 = ax0;
         p1 = ax1;
         p2 = ax2;
         case (d)
            3'd0: begin
               ax0 = p2; ax1 = p1; ax2 = p0;
            end
            3'd1: begin
               ax0 = p0; ax1 = p2; ax2 = p1;
            end
            3'd3: begin
               ax0 = p2 ^ 3'd1; ax1 = p0 ^ 3'd1; ax2 = p1;
            end
            3'd4: begin
               ax0 = p2; ax1 = p0 ^ 3'd1; ax2 = p1 ^ 3'd1;
            end
            3'd6: begin
               ax0 = p0; ax1 = p2 ^ 3'd1; ax2 = p1 ^ 3'd1;
            end
            3'd7: begin
               ax0 = p2 ^ 3'd1; ax1 = p1; ax2 = p0 ^ 3'd1;
            end
            default: ;
         endcase
      end
      return key;
   endfunction

   function automatic logic [WORD_W-1:0] random_coord();
      logic [WORD_W-1:0] c;
      case ($urandom_range(0, 5))
         0:       c = '0;
         1:       c = '1;
         2:       c = 32'd1 << $urandom_range(0, WORD_W - 1);
         3:       c = $urandom() & $urandom();
         4:       c = $urandom() | $urandom();
         default: c = $urandom();
      endcase
      return c;
   endfunction

   function automatic void add_row(logic [KEY_WORDS_W-1:0] kw, logic [WORD_W-1:0] x,
                                   logic [WORD_W-1:0] y, logic [WORD_W-1:0] z,
                                   bit typed, logic [KEY_W-1:0] key);
      point_row_type row;
      row.key_words = kw;
      row.pt = {x, y, z};
      row.typed = typed;
      row.key = key;
      point_rows.push_back(row);
   endfunction

   task automatic offer_point(req_type pt, rsp_type key);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pt;
      do @(posedge clock); while (!req_ready);
      pending_keys.push_back(key);
      points_sent++;
   endtask

   task automatic drain_keys();
      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
   endtask

   task automatic write_key_words(logic [KEY_WORDS_W-1:0] kw);
      csr_valid <= 1'b1;
      csr_data <= kw;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_words_now = kw;
   endtask

   // result receiver: short random stalls, plus one long hold-off
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_pending && points_sent >= STALL_AT) begin
            stall_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_keys.size() == 0) begin
            $error("unexpected key %h", rsp_data);
            errors++;
         end else begin
            want = pending_keys.pop_front();
            keys_checked++;
            if (rsp_data.key_word0 !== want.key_word0) begin
               $error("key_word0: expected %h, got %h", want.key_word0, rsp_data.key_word0);
               errors++;
            end
            if (rsp_data.key_word1 !== want.key_word1) begin
               $error("key_word1: expected %h, got %h", want.key_word1, rsp_data.key_word1);
               errors++;
            end
            if (rsp_data.key_word2 !== want.key_word2) begin
               $error("key_word2: expected %h, got %h", want.key_word2, rsp_data.key_word2);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      static int kw_seq [NUM_PHASES] = '{3, 0, 1, 2, 3, 2, 1, 3};
      static int send_pct [NUM_PHASES] = '{20, 30, 0, 25, 40, 10, 30, 0};
      static int rsp_pct [NUM_PHASES] = '{25, 20, 0, 35, 15, 40, 20, 0};
      req_type pt;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      key_words_now = KEY_WORDS_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed points; typed keys only where the walk is trivial
      add_row(2'd3, 32'h0, 32'h0, 32'h0, 1, '0);
      add_row(2'd3, 32'h8000_0000, 32'h0, 32'h0, 1, {32'h2000_0000, 32'h0, 32'h0});
      add_row(2'd3, 32'h0, 32'h8000_0000, 32'h0, 0, '0);
      add_row(2'd3, 32'h0, 32'h0, 32'h8000_0000, 0, '0);
      add_row(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0);
      add_row(2'd3, 32'hffff_ffff, 32'h0, 32'h0, 0, '0);
      add_row(2'd3, 32'h0, 32'hffff_ffff, 32'h0, 0, '0);
      add_row(2'd3, 32'h0, 32'h0, 32'hffff_ffff, 0, '0);
      add_row(2'd3, 32'h1, 32'h1, 32'h1, 0, '0);
      add_row(2'd3, 32'haaaa_aaaa, 32'h5555_5555, 32'hcccc_cccc, 0, '0);
      // no key words: all zero
      add_row(2'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, '0);
      add_row(2'd0, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 1, '0);
      // coordinate bits below the last level are not reached
      add_row(2'd1, 32'h0, 32'h0, 32'h0, 1, '0);
      add_row(2'd1, 32'h8000_0000, 32'h0, 32'h0, 1, {32'h2000_0000, 32'h0, 32'h0});
      add_row(2'd1, 32'h003f_ffff, 32'h003f_ffff, 32'h003f_ffff, 1, '0);
      add_row(2'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0);
      add_row(2'd2, 32'h0000_07ff, 32'h0000_07ff, 32'h0000_07ff, 1, '0);
      add_row(2'd2, 32'h8000_0000, 32'h0, 32'h0, 1, {32'h2000_0000, 32'h0, 32'h0});
      add_row(2'd2, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0);
      add_row(2'd2, 32'h0, 32'h0, 32'h1, 0, '0);
      add_row(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffe, 0, '0);

      send_idle_pct = 25;
      rsp_idle_pct = 25;
      foreach (point_rows[i]) begin
         if (i == 0 || point_rows[i].key_words != key_words_now) begin
            drain_keys();
            write_key_words(point_rows[i].key_words);
         end
         offer_point(point_rows[i].pt, point_rows[i].typed ? point_rows[i].key :
                     hilbert_key(point_rows[i].pt, key_words_now));
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_keys();
         write_key_words(KEY_WORDS_W'(kw_seq[ph]));
         send_idle_pct = send_pct[ph];
         rsp_idle_pct = rsp_pct[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender waits for the pipeline to empty once, mid-run
            if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2)
               drain_keys();
            pt.coord_x = random_coord();
            pt.coord_y = random_coord();
            pt.coord_z = random_coord();
            offer_point(pt, hilbert_key(pt, key_words_now));
         end
      end

      drain_keys();
      repeat (SETTLE) @(posedge clock);
      if (pending_keys.size() != 0) begin
         $error("%0d keys never arrived", pending_keys.size());
         errors++;
      end
      $display("Keyed %0d points over key-word counts 0 to 3, %0d keys compared.",
               points_sent, keys_checked);
      $display("Included a %0d-cycle result hold-off and a full pipeline drain.", LONG_STALL);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: hilbert_key_3d_unit.f
+incdir+design
design/hk3_pkg.sv
design/hk3_stage.sv
design/hilbert_key_3d_unit.sv
bench/tb_hilbert_key_3d_unit.sv
